>>> src/assert_macros.svh
// assertion helpers used by the checker file lzwd_chk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge outside reset
`define LZWD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lzwd check failed");

// checked at every edge, reset included
`define LZWD_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lzwd check failed");

`endif

>>> src/lzwd_pkg.sv
package lzwd_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = ADDR_W + 1;
  localparam logic [ADDR_W-1:0] WRITE_START = ADDR_W'(12'hfee);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);
  localparam int RUN_W = 5;
  localparam logic [RUN_W-1:0] RUN_EXTRA = RUN_W'(2);

  typedef struct packed {
    logic [7:0] code_byte;
    logic       stream_end;
  } code_item_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       run_last;
  } plain_item_t;

endpackage

>>> src/lzwd_engine.sv
module lzwd_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 code_valid,
  output logic                 code_stall,
  input  lzwd_pkg::code_item_t code_item,
  output logic                 plain_valid,
  input  logic                 plain_stall,
  output lzwd_pkg::plain_item_t plain_item
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_COPY = 1'b1;

  logic state;
  logic state_next;

  logic [7:0] window [lzwd_pkg::WINDOW_DEPTH];
  logic [7:0] mem_q;

  logic [lzwd_pkg::ADDR_W-1:0] wpos;
  logic [lzwd_pkg::FILL_W-1:0] fill;
  logic [7:0] token_bits;
  logic [3:0] bits_left;
  logic       phase;
  logic [7:0] off_low;

  logic [lzwd_pkg::ADDR_W-1:0] src;
  logic [lzwd_pkg::RUN_W-1:0]  remaining;
  logic       last_rd;
  logic       end_pending;
  logic       rd_zero;
  logic       fwd_hit;
  logic [7:0] fwd_byte;

  logic       out_valid;
  lzwd_pkg::plain_item_t out_item;

  logic       out_free;
  logic       accept;
  logic       do_ref;
  logic       do_flag;
  logic       do_lit;
  logic       copy_emit;
  logic       we;
  logic [7:0] wdata;
  logic       re;
  logic [lzwd_pkg::ADDR_W-1:0] raddr;
  logic [lzwd_pkg::ADDR_W-1:0] rdiff;
  logic [lzwd_pkg::ADDR_W-1:0] ref_pos;
  logic [7:0] copy_byte;
  logic [lzwd_pkg::FILL_W-1:0] fill_inc;

  assign out_free   = !out_valid || !plain_stall;
  assign code_stall = (state != ST_IDLE) || !out_free;
  assign accept     = code_valid && !code_stall;

  assign do_ref  = accept && phase;
  assign do_flag = accept && !phase && (bits_left == 4'd0);
  assign do_lit  = accept && !phase && (bits_left != 4'd0) && token_bits[0];

  assign copy_emit = (state == ST_COPY) && out_free;
  assign copy_byte = fwd_hit ? fwd_byte : (rd_zero ? 8'd0 : mem_q);

  assign ref_pos = {code_item.code_byte[7:4], off_low};

  assign we    = do_lit || copy_emit;
  assign wdata = do_lit ? code_item.code_byte : copy_byte;
  assign re    = do_ref || (copy_emit && !last_rd);
  assign raddr = do_ref ? ref_pos : src;
  assign rdiff = raddr - lzwd_pkg::WRITE_START;

  assign fill_inc = (fill == lzwd_pkg::FILL_FULL) ? fill : fill + 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (do_ref) state_next = ST_COPY;
      end
      ST_COPY: begin
        if (copy_emit && last_rd) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // window memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      window[wpos] <= wdata;
    end
    if (re) begin
      mem_q <= window[raddr];
    end
  end

  // read side bookkeeping: unwritten entries read as zero, same-cycle writes forwarded
  always_ff @(posedge clk) begin
    if (re) begin
      rd_zero  <= ({1'b0, rdiff} >= fill);
      fwd_hit  <= !do_ref && (raddr == wpos);
      fwd_byte <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      wpos        <= lzwd_pkg::WRITE_START;
      fill        <= '0;
      token_bits  <= '0;
      bits_left   <= '0;
      phase       <= 1'b0;
      off_low     <= '0;
      end_pending <= 1'b0;
      out_valid   <= 1'b0;
      remaining   <= '0;
      last_rd     <= 1'b0;
    end else begin
      state <= state_next;
      if (out_free) begin
        out_valid <= do_lit || copy_emit;
      end
      if (we) begin
        wpos <= wpos + 1'b1;
        fill <= fill_inc;
      end
      if (do_flag) begin
        token_bits <= code_item.code_byte;
        bits_left  <= 4'd8;
      end else if (accept && !phase) begin
        token_bits <= token_bits >> 1;
        bits_left  <= bits_left - 4'd1;
        if (!token_bits[0]) begin
          off_low <= code_item.code_byte;
          phase   <= 1'b1;
        end
      end
      if (do_ref) begin
        phase       <= 1'b0;
        src         <= ref_pos + 1'b1;
        remaining   <= {1'b0, code_item.code_byte[3:0]} + lzwd_pkg::RUN_EXTRA;
        last_rd     <= 1'b0;
        end_pending <= code_item.stream_end;
      end
      if (copy_emit && !last_rd) begin
        src       <= src + 1'b1;
        remaining <= remaining - 1'b1;
        last_rd   <= (remaining == lzwd_pkg::RUN_W'(1));
      end
      // stream end returns the write position, fill count and token decode state to their start values
      if ((accept && !do_ref && code_item.stream_end) ||
          (copy_emit && last_rd && end_pending)) begin
        wpos        <= lzwd_pkg::WRITE_START;
        fill        <= '0;
        token_bits  <= '0;
        bits_left   <= '0;
        phase       <= 1'b0;
        off_low     <= '0;
        end_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (do_lit) begin
        out_item.plain_byte <= code_item.code_byte;
        out_item.run_last   <= 1'b1;
      end else if (copy_emit) begin
        out_item.plain_byte <= copy_byte;
        out_item.run_last   <= last_rd;
      end
    end
  end

  assign plain_valid = out_valid;
  assign plain_item  = out_item;

endmodule

>>> src/lzss_window_decoder_unit.sv
// channel   dir  handshake                  payload
// code      in   code_valid / code_stall    code_item  (code_byte, stream_end)
// plain     out  plain_valid / plain_stall  plain_item (plain_byte, run_last)
//
// flag bytes and reference low bytes give no item
// a literal gives one item; a reference gives its bytes one per cycle while
// plain_stall is low, through the single read port of the 4096-byte window
// reset is synchronous; the window needs no clearing pass, entries not yet
// written since reset or stream end read as zero
// a plain stall holds the copy engine and stalls the code channel
module lzss_window_decoder_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  code_valid,
  output logic                  code_stall,
  input  lzwd_pkg::code_item_t  code_item,
  output logic                  plain_valid,
  input  logic                  plain_stall,
  output lzwd_pkg::plain_item_t plain_item
);

  lzwd_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .code_valid  (code_valid),
    .code_stall  (code_stall),
    .code_item   (code_item),
    .plain_valid (plain_valid),
    .plain_stall (plain_stall),
    .plain_item  (plain_item)
  );

endmodule

>>> src/lzwd_chk.sv
`include "assert_macros.svh"

module lzwd_chk (
  input logic                  clk,
  input logic                  rst,
  input logic                  code_valid,
  input logic                  code_stall,
  input lzwd_pkg::code_item_t  code_item,
  input logic                  plain_valid,
  input logic                  plain_stall,
  input lzwd_pkg::plain_item_t plain_item
);

  `LZWD_ASSERT(a_code_hold, clk, rst, code_valid && code_stall |=> code_valid && $stable(code_item))
  `LZWD_ASSERT(a_plain_hold, clk, rst, plain_valid && plain_stall |=> plain_valid && $stable(plain_item))
  `LZWD_ASSERT(a_mid_run_blocks, clk, rst, plain_valid && !plain_item.run_last |-> code_stall)
  `LZWD_ASSERT(a_stall_backs_up, clk, rst, plain_valid && plain_stall |-> code_stall)
  `LZWD_ASSERT_ALL(a_reset_empty, clk, rst |=> !plain_valid)

endmodule

bind lzss_window_decoder_unit lzwd_chk u_lzwd_chk (
  .clk         (clk),
  .rst         (rst),
  .code_valid  (code_valid),
  .code_stall  (code_stall),
  .code_item   (code_item),
  .plain_valid (plain_valid),
  .plain_stall (plain_stall),
  .plain_item  (plain_item)
);

>>> tb/sv/lzss_window_decoder_checker.sv
`timescale 1ns / 100ps

module lzss_window_decoder_checker
  import lzwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        code_valid,
  input  logic        code_stall,
  input  code_item_t  code_item,
  input  logic        plain_valid,
  input  logic        plain_stall,
  input  plain_item_t plain_item,
  output int          errors,
  output int          waiting,
  output int          matched
);

  typedef enum logic [1:0] {
    TOKEN_OR_LOW = 2'd0,
    REF_HIGH     = 2'd1
  } phase_t;

  logic [7:0]        window_mem [WINDOW_DEPTH];
  logic [ADDR_W-1:0] wr_pos;
  logic [7:0]        flag_bits;
  logic [3:0]        flags_left;
  phase_t            phase;
  logic [7:0]        offset_low;
  plain_item_t       expected_bytes [$];
  plain_item_t       want;

  function automatic void clear_history();
    foreach (window_mem[i]) window_mem[i] = 8'h00;
    wr_pos     = WRITE_START;
    flag_bits  = 8'h00;
    flags_left = 4'd0;
    phase      = TOKEN_OR_LOW;
    offset_low = 8'h00;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    plain_item_t p;
    window_mem[wr_pos] = b;
    wr_pos = wr_pos + 1'b1;
    p.plain_byte = b;
    p.run_last   = 1'b0;
    expected_bytes.push_back(p);
  endfunction

  function automatic void decode_code(input code_item_t c);
    int                n;
    int                len;
    int                i;
    logic [ADDR_W-1:0] src;
    plain_item_t       tail;
    n = expected_bytes.size();
    if (phase == REF_HIGH) begin
      src = {c.code_byte[7:4], offset_low};
      len = int'(c.code_byte[3:0]) + 3;
      for (i = 0; i < len; i++) put_byte(window_mem[src + ADDR_W'(i)]);
      phase = TOKEN_OR_LOW;
    end else if (flags_left == 4'd0) begin
      flag_bits  = c.code_byte;
      flags_left = 4'd8;
      phase      = TOKEN_OR_LOW;
    end else begin
      flags_left = flags_left - 4'd1;
      if (flag_bits[0]) begin
        put_byte(c.code_byte);
        phase = TOKEN_OR_LOW;
      end else begin
        offset_low = c.code_byte;
        phase      = REF_HIGH;
      end
      flag_bits = flag_bits >> 1;
    end
    // last byte caused by this item carries run_last
    if (expected_bytes.size() > n) begin
      tail = expected_bytes.pop_back();
      tail.run_last = 1'b1;
      expected_bytes.push_back(tail);
    end
    if (c.stream_end) clear_history();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_history();
      expected_bytes.delete();
      errors  = 0;
      matched = 0;
    end else begin
      if (plain_valid && !plain_stall) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          $error("plain item with nothing expected: plain_byte %h run_last %b",
                 plain_item.plain_byte, plain_item.run_last);
        end else begin
          want = expected_bytes.pop_front();
          if (plain_item.plain_byte !== want.plain_byte) begin
            errors++;
            $error("plain_byte mismatch: expected %h, actual %h",
                   want.plain_byte, plain_item.plain_byte);
          end
          if (plain_item.run_last !== want.run_last) begin
            errors++;
            $error("run_last mismatch: expected %b, actual %b",
                   want.run_last, plain_item.run_last);
          end
          matched++;
        end
      end
      if (code_valid && !code_stall) decode_code(code_item);
    end
    waiting = expected_bytes.size();
  end

endmodule

>>> tb/sv/lzss_window_decoder_unit_tb.sv
`timescale 1ns / 100ps

module lzss_window_decoder_unit_tb;
  import lzwd_pkg::*;

  localparam int RANDOM_ITEMS = 360;
  localparam int IDLE_PCT [4]  = '{0, 88, 0, 20};
  localparam int STALL_PCT [4] = '{0, 0, 88, 20};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        code_valid = 1'b0;
  logic        code_stall;
  code_item_t  code_item = '0;
  logic        plain_valid;
  logic        plain_stall = 1'b0;
  plain_item_t plain_item;

  int errors;
  int waiting;
  int matched;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int streams = 0;

  logic [ADDR_W-1:0] gen_pos;
  logic [7:0]        gen_flags;
  int                gen_left;
  code_item_t        stream_q [$];

  lzss_window_decoder_unit uut (
    .clk         (clk),
    .rst         (rst),
    .code_valid  (code_valid),
    .code_stall  (code_stall),
    .code_item   (code_item),
    .plain_valid (plain_valid),
    .plain_stall (plain_stall),
    .plain_item  (plain_item)
  );

  lzss_window_decoder_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .code_valid  (code_valid),
    .code_stall  (code_stall),
    .code_item   (code_item),
    .plain_valid (plain_valid),
    .plain_stall (plain_stall),
    .plain_item  (plain_item),
    .errors      (errors),
    .waiting     (waiting),
    .matched     (matched)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    plain_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic push_code(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      code_valid <= 1'b0;
      @(negedge clk);
    end
    code_valid <= 1'b1;
    code_item  <= '{code_byte: b, stream_end: last};
    @(posedge clk);
    while (code_stall) @(posedge clk);
    @(negedge clk);
    sent++;
    if (last) streams++;
  endtask

  task automatic add_flag();
    gen_flags = 8'($urandom);
    gen_left  = 8;
    stream_q.push_back('{code_byte: gen_flags, stream_end: 1'b0});
  endtask

  task automatic add_token();
    logic [ADDR_W-1:0] src;
    logic [3:0]        len;
    if (gen_left == 0) add_flag();
    gen_left--;
    if (gen_flags[0]) begin
      stream_q.push_back('{code_byte: 8'($urandom), stream_end: 1'b0});
      gen_pos = gen_pos + 1'b1;
    end else begin
      // mostly short distances back, so copies hit fresh and overlapping data
      if ($urandom_range(3) != 0) src = gen_pos - ADDR_W'($urandom_range(1, 48));
      else src = ADDR_W'($urandom);
      len = 4'($urandom);
      stream_q.push_back('{code_byte: src[7:0], stream_end: 1'b0});
      stream_q.push_back('{code_byte: {src[11:8], len}, stream_end: 1'b0});
      gen_pos = gen_pos + ADDR_W'(len) + ADDR_W'(3);
    end
    gen_flags = gen_flags >> 1;
  endtask

  task automatic send_stream();
    code_item_t c;
    stream_q.delete();
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 24))
        stream_q.push_back('{code_byte: 8'($urandom), stream_end: 1'b0});
    end else begin
      gen_pos  = WRITE_START;
      gen_left = 0;
      repeat ($urandom_range(1, 40)) add_token();
      // cut off the stream inside a token now and then
      if ($urandom_range(99) < 20) begin
        if (gen_left == 0) add_flag();
        else stream_q.push_back('{code_byte: 8'($urandom), stream_end: 1'b0});
      end
    end
    c = stream_q.pop_back();
    c.stream_end = 1'b1;
    stream_q.push_back(c);
    foreach (stream_q[i]) push_code(stream_q[i].code_byte, stream_q[i].stream_end);
  endtask

  initial begin
    int goal;
    int directed;
    int ph;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // literals, an overlapping copy onto the write position, extreme bytes
    push_code(8'hfd, 1'b0);
    push_code(8'h00, 1'b0);
    push_code(8'hee, 1'b0);
    push_code(8'hf0, 1'b0);
    push_code(8'hff, 1'b0);
    push_code(8'ha5, 1'b0);
    push_code(8'h5a, 1'b0);
    push_code(8'h80, 1'b0);
    push_code(8'h01, 1'b0);
    push_code(8'h7f, 1'b0);
    // all references, longest length, low and high window positions
    push_code(8'h00, 1'b0);
    push_code(8'hff, 1'b0);
    push_code(8'h0f, 1'b0);
    push_code(8'h00, 1'b0);
    push_code(8'hff, 1'b0);
    push_code(8'hf0, 1'b0);
    push_code(8'hff, 1'b0);
    // stream ends on a reference low byte, then on a flag byte
    push_code(8'h12, 1'b1);
    push_code(8'h01, 1'b1);
    // stream ends on a literal
    push_code(8'h01, 1'b0);
    push_code(8'hc3, 1'b1);
    // window must read back as zero after the stream end
    push_code(8'h00, 1'b0);
    push_code(8'hee, 1'b0);
    push_code(8'hf2, 1'b1);
    directed = sent;

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = IDLE_PCT[ph];
      stall_pct     = STALL_PCT[ph];
      goal = directed + (ph + 1) * (RANDOM_ITEMS / 4);
      while (sent < goal) send_stream();
    end
    code_valid <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;

    wait (waiting == 0);
    repeat (40) @(posedge clk);

    $display("sent %0d code items (%0d directed) in %0d streams, %0d plain items checked",
             sent, directed, streams, matched);
    $display("idle mixes run: none, sender 88%%, receiver 88%%, both 20%%");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d plain items still expected", waiting);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> lzss_window_decoder_unit.f
+incdir+src
src/lzwd_pkg.sv
src/lzwd_engine.sv
src/lzss_window_decoder_unit.sv
src/lzwd_chk.sv
tb/sv/lzss_window_decoder_checker.sv
tb/sv/lzss_window_decoder_unit_tb.sv
